/* hdl/tdcinl_pkg.sv */
// tdcinl_pkg: shared types, field widths, action and status codes and the
// control structs passed between the sequencer and the memory blocks.
// No dependencies.
package tdcinl_pkg;

   // Field types of a request and response beat
   typedef logic        [1:0]  action_type;
   typedef logic        [1:0]  status_type;
   typedef logic        [6:0]  tray_type;
   typedef logic        [2:0]  position_type;
   typedef logic        [9:0]  board_id_type;
   typedef logic        [7:0]  channel_type;
   typedef logic        [9:0]  bin_type;
   typedef logic signed [15:0] corr_type;

   // Request actions
   localparam action_type ACT_LOAD_MAP  = 2'd0;
   localparam action_type ACT_LOAD_CORR = 2'd1;
   localparam action_type ACT_BY_TRAY   = 2'd2;
   localparam action_type ACT_BY_BOARD  = 2'd3;

   // Response status
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FALLBACK = 2'd1;
   localparam status_type ST_RANGE    = 2'd2;

   // Width used for range compares and the tray row arithmetic
   localparam int CMP_W = 13;

   // Number of codes a channel field can carry
   localparam int CHAN_CODES = 2 ** $bits(channel_type);

   // Control of the tray map and board slot map
   typedef struct packed {
      logic clear;
      logic tray_rd;
      logic tray_wr;
      logic slot_rd;
      logic slot_wr;
   } map_ctrl_type;

   // Control of the correction store
   typedef struct packed {
      logic clear;
      logic rd;
      logic wr;
   } store_ctrl_type;

endpackage

/* hdl/tdc_inl_correction_lookup.sv */
// Requests are decoded, then served by chained reads of tray map, slot map and
// correction store, each with registered read data; the block takes one item at
// a time and holds req_stall high until the result has gone to the output register.
// Reset starts a clearing pass over all three memories during which req_stall stays high.
module tdc_inl_correction_lookup #(
   parameter int NUM_TRAYS          = 120,
   parameter int BOARDS_PER_TRAY    = 8,
   parameter int CHANNELS_PER_BOARD = 24,
   parameter int BINS               = 1024,
   parameter int MAX_BOARDS         = 16,
   parameter int MAX_BOARD_ID       = 1023
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tdcinl_pkg::action_type    req_action,
   input  tdcinl_pkg::tray_type      req_tray,
   input  tdcinl_pkg::position_type  req_position,
   input  tdcinl_pkg::board_id_type  req_board_id,
   input  tdcinl_pkg::channel_type   req_channel,
   input  tdcinl_pkg::bin_type       req_bin,
   input  tdcinl_pkg::corr_type      req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tdcinl_pkg::corr_type      rsp_correction,
   output tdcinl_pkg::status_type    rsp_status
);
   import tdcinl_pkg::*;

   localparam int TM_DEPTH  = (NUM_TRAYS + 2) * BOARDS_PER_TRAY;
   localparam int SM_DEPTH  = MAX_BOARD_ID + 1;
   localparam int ROWS      = MAX_BOARDS * CHANNELS_PER_BOARD;
   localparam int ST_DEPTH  = ROWS * BINS;
   localparam int MAP_DEPTH = (TM_DEPTH > SM_DEPTH) ? TM_DEPTH : SM_DEPTH;
   localparam int CLR_DEPTH = (ST_DEPTH > MAP_DEPTH) ? ST_DEPTH : MAP_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int SLOT_W    = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
   localparam int CNT_W     = $clog2(MAX_BOARDS + 1);
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_TRAY  = 4'd3;
   localparam logic [3:0] S_SLOT  = 4'd4;
   localparam logic [3:0] S_RDST  = 4'd5;
   localparam logic [3:0] S_DATA  = 4'd6;
   localparam logic [3:0] S_LWR   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   board_id_type      last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   action_type        act_ff, act_in;
   tray_type          tray_ff, tray_in;
   position_type      pos_ff, pos_in;
   board_id_type      id_ff, id_in;
   channel_type       chan_ff, chan_in;
   bin_type           bin_ff, bin_in;
   corr_type          value_ff, value_in;
   channel_type       cb_ff, cb_in;
   logic              cok_ff, cok_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   corr_type          res_corr_ff, res_corr_in;
   status_type        res_status_ff, res_status_in;
   corr_type          rsp_corr_ff, rsp_corr_in;
   status_type        rsp_status_ff, rsp_status_in;

   map_ctrl_type      map_ctrl;
   store_ctrl_type    store_ctrl;
   channel_type       tray_sub;
   board_id_type      slot_id;
   board_id_type      tray_rdata;
   logic              slot_valid;
   logic [SLOT_W-1:0] slot_rdata;
   corr_type          store_rdata;

   channel_type       quo_tab [CHAN_CODES];
   channel_type       rem_tab [CHAN_CODES];

   logic              bin_ok, tray_ok, pos_ok, gchan_ok, chan_ok, id_ok, brd_ok;
   logic              new_board, full;
   logic [CNT_W-1:0]  slot_sel;
   logic [CNT_W-1:0]  mul_slot;
   channel_type       mul_chan;
   logic [ROW_W-1:0]  row_calc;
   logic              have;

   // Channel to board position and channel on board, constant tables
   for (genvar g = 0; g < CHAN_CODES; g++) begin : g_div
      assign quo_tab[g] = 8'(g / CHANNELS_PER_BOARD);
      assign rem_tab[g] = 8'(g % CHANNELS_PER_BOARD);
   end

   // Range checks on the held request
   assign bin_ok   = CMP_W'(bin_ff) < CMP_W'(BINS);
   assign tray_ok  = (tray_ff != '0) && (CMP_W'(tray_ff) <= CMP_W'(NUM_TRAYS + 2));
   assign pos_ok   = CMP_W'(pos_ff) < CMP_W'(BOARDS_PER_TRAY);
   assign gchan_ok = CMP_W'(chan_ff) < CMP_W'(BOARDS_PER_TRAY * CHANNELS_PER_BOARD);
   assign chan_ok  = CMP_W'(chan_ff) < CMP_W'(CHANNELS_PER_BOARD);
   assign id_ok    = (id_ff != '0) && (CMP_W'(id_ff) <= CMP_W'(MAX_BOARD_ID));
   assign brd_ok   = (tray_rdata != '0) && (CMP_W'(tray_rdata) <= CMP_W'(MAX_BOARD_ID));

   // Slot bookkeeping for correction loads
   assign new_board = (count_ff == '0) || (id_ff != last_ff);
   assign full      = count_ff >= CNT_W'(MAX_BOARDS);
   assign slot_sel  = new_board ? count_ff : count_ff - CNT_W'(1);

   // Shared row multiplier: slot * channels per board + channel on board
   assign mul_slot = (state_ff == S_SLOT) ? CNT_W'(slot_rdata) : slot_sel;
   assign mul_chan = (state_ff == S_SLOT) ? cb_ff : chan_ff;
   assign row_calc = ROW_W'(mul_slot) * ROW_W'(CHANNELS_PER_BOARD) + ROW_W'(mul_chan);

   // Found a loaded table for the board
   assign have = cok_ff && slot_valid && (CNT_W'(slot_rdata) < count_ff);

   // Map addressing
   assign tray_sub = (act_ff == ACT_LOAD_MAP) ? {5'd0, pos_ff} : quo_tab[chan_ff];
   assign slot_id  = (state_ff == S_TRAY) ? tray_rdata : id_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      act_in        = act_ff;
      tray_in       = tray_ff;
      pos_in        = pos_ff;
      id_in         = id_ff;
      chan_in       = chan_ff;
      bin_in        = bin_ff;
      value_in      = value_ff;
      cb_in         = cb_ff;
      cok_in        = cok_ff;
      row_in        = row_ff;
      res_corr_in   = res_corr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_corr_in   = rsp_corr_ff;
      rsp_status_in = rsp_status_ff;
      map_ctrl      = '0;
      store_ctrl    = '0;

      // Response beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            map_ctrl.clear   = 1'b1;
            store_ctrl.clear = 1'b1;
            clr_in           = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               tray_in  = req_tray;
               pos_in   = req_position;
               id_in    = req_board_id;
               chan_in  = req_channel;
               bin_in   = req_bin;
               value_in = req_value;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            res_corr_in   = '0;
            res_status_in = ST_OK;
            state_in      = S_DONE;
            case (act_ff)
               ACT_LOAD_MAP: begin
                  if (tray_ok && pos_ok) begin
                     map_ctrl.tray_wr = 1'b1;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               ACT_LOAD_CORR: begin
                  if (new_board && full) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     if (new_board) begin
                        count_in         = count_ff + CNT_W'(1);
                        map_ctrl.slot_wr = id_ok;
                     end
                     last_in = id_ff;
                     row_in  = row_calc;
                     if (chan_ok && bin_ok) begin
                        state_in = S_LWR;
                     end else begin
                        res_status_in = ST_RANGE;
                     end
                  end
               end
               ACT_BY_TRAY: begin
                  if (tray_ok && gchan_ok && bin_ok) begin
                     map_ctrl.tray_rd = 1'b1;
                     cb_in            = rem_tab[chan_ff];
                     cok_in           = 1'b1;
                     state_in         = S_TRAY;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               ACT_BY_BOARD: begin
                  if (bin_ok) begin
                     map_ctrl.slot_rd = 1'b1;
                     cb_in            = chan_ff;
                     cok_in           = chan_ok && id_ok;
                     state_in         = S_SLOT;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               default: begin
                  res_status_in = ST_RANGE;
               end
            endcase
         end
         S_TRAY: begin
            if (brd_ok) begin
               map_ctrl.slot_rd = 1'b1;
               state_in         = S_SLOT;
            end else begin
               res_status_in = ST_RANGE;
               state_in      = S_DONE;
            end
         end
         S_SLOT: begin
            // No table: slot 0, channel 0, same bin
            if (have) begin
               row_in        = row_calc;
               res_status_in = ST_OK;
            end else begin
               row_in        = '0;
               res_status_in = ST_FALLBACK;
            end
            state_in = S_RDST;
         end
         S_RDST: begin
            store_ctrl.rd = 1'b1;
            state_in      = S_DATA;
         end
         S_DATA: begin
            res_corr_in = store_rdata;
            state_in    = S_DONE;
         end
         S_LWR: begin
            store_ctrl.wr = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_corr_in   = res_corr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      tray_ff       <= tray_in;
      pos_ff        <= pos_in;
      id_ff         <= id_in;
      chan_ff       <= chan_in;
      bin_ff        <= bin_in;
      value_ff      <= value_in;
      cb_ff         <= cb_in;
      cok_ff        <= cok_in;
      row_ff        <= row_in;
      res_corr_ff   <= res_corr_in;
      res_status_ff <= res_status_in;
      rsp_corr_ff   <= rsp_corr_in;
      rsp_status_ff <= rsp_status_in;
   end

   tdcinl_maps #(
      .NUM_TRAYS       (NUM_TRAYS),
      .BOARDS_PER_TRAY (BOARDS_PER_TRAY),
      .MAX_BOARDS      (MAX_BOARDS),
      .MAX_BOARD_ID    (MAX_BOARD_ID),
      .CLR_W           (CLR_W)
   ) u_maps (
      .clock      (clock),
      .ctrl       (map_ctrl),
      .clr_idx    (clr_ff),
      .tray       (tray_ff),
      .sub        (tray_sub),
      .tray_wdata (id_ff),
      .slot_id    (slot_id),
      .slot_wdata (SLOT_W'(count_ff)),
      .tray_rdata (tray_rdata),
      .slot_valid (slot_valid),
      .slot_rdata (slot_rdata)
   );

   tdcinl_store #(
      .MAX_BOARDS         (MAX_BOARDS),
      .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
      .BINS               (BINS),
      .CLR_W              (CLR_W)
   ) u_store (
      .clock   (clock),
      .ctrl    (store_ctrl),
      .clr_idx (clr_ff),
      .row     (row_ff),
      .bin     (bin_ff),
      .wdata   (value_ff),
      .rdata   (store_rdata)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_correction = rsp_corr_ff;
   assign rsp_status     = rsp_status_ff;

   // Slot count never passes the slot limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BOARDS))
      else $error("loaded board count above slot limit");

   // Slot count only grows between resets
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("loaded board count went down");

   // Rejected requests carry a zero correction
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_RANGE) |-> rsp_corr_ff == '0)
      else $error("out of range response with non-zero correction");

   // A finished result waits while the output beat is stalled
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == S_DONE)
      else $error("result left while output register was full");

   // Load responses carry a zero correction
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (act_ff == ACT_LOAD_MAP || act_ff == ACT_LOAD_CORR))
      |-> res_corr_ff == '0)
      else $error("load response with non-zero correction");

endmodule

/* hdl/tdcinl_maps.sv */
// tdcinl_maps: tray-position-to-board map and board-ID-to-slot map, both
// single-port synchronous memories with registered read data.
// Depends on tdcinl_pkg.
module tdcinl_maps #(
   parameter int NUM_TRAYS       = 120,
   parameter int BOARDS_PER_TRAY = 8,
   parameter int MAX_BOARDS      = 16,
   parameter int MAX_BOARD_ID    = 1023,
   parameter int CLR_W           = 19,
   localparam int SLOT_W         = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1
) (
   input  logic                       clock,
   input  tdcinl_pkg::map_ctrl_type   ctrl,
   input  logic [CLR_W-1:0]           clr_idx,
   input  tdcinl_pkg::tray_type       tray,
   input  tdcinl_pkg::channel_type    sub,
   input  tdcinl_pkg::board_id_type   tray_wdata,
   input  tdcinl_pkg::board_id_type   slot_id,
   input  logic [SLOT_W-1:0]          slot_wdata,
   output tdcinl_pkg::board_id_type   tray_rdata,
   output logic                       slot_valid,
   output logic [SLOT_W-1:0]          slot_rdata
);
   import tdcinl_pkg::*;

   localparam int TM_DEPTH = (NUM_TRAYS + 2) * BOARDS_PER_TRAY;
   localparam int TM_AW    = $clog2(TM_DEPTH);
   localparam int SM_DEPTH = MAX_BOARD_ID + 1;
   localparam int SM_AW    = $clog2(SM_DEPTH);

   board_id_type        tray_mem [TM_DEPTH];
   logic [SLOT_W:0]     slot_mem [SM_DEPTH];

   board_id_type        tray_rdata_ff;
   logic [SLOT_W:0]     slot_rdata_ff;

   logic [CMP_W-1:0]    tray_lin;
   logic [TM_AW-1:0]    tray_idx;
   logic [SM_AW-1:0]    slot_idx;
   logic                tm_clr_hit;
   logic                sm_clr_hit;

   // Row of the tray map: (tray - 1) * boards per tray + position
   assign tray_lin = (CMP_W'(tray) - CMP_W'(1)) * CMP_W'(BOARDS_PER_TRAY) + CMP_W'(sub);
   assign tray_idx = TM_AW'(tray_lin);
   assign slot_idx = SM_AW'(slot_id);

   // Clearing pass covers only the entries each map has
   assign tm_clr_hit = {1'b0, clr_idx} < (CLR_W + 1)'(TM_DEPTH);
   assign sm_clr_hit = {1'b0, clr_idx} < (CLR_W + 1)'(SM_DEPTH);

   // Tray map
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         if (tm_clr_hit) begin
            tray_mem[TM_AW'(clr_idx)] <= '0;
         end
      end else if (ctrl.tray_wr) begin
         tray_mem[tray_idx] <= tray_wdata;
      end
      if (ctrl.tray_rd) begin
         tray_rdata_ff <= tray_mem[tray_idx];
      end
   end

   // Board slot map, top bit is the valid flag
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         if (sm_clr_hit) begin
            slot_mem[SM_AW'(clr_idx)] <= '0;
         end
      end else if (ctrl.slot_wr) begin
         slot_mem[slot_idx] <= {1'b1, slot_wdata};
      end
      if (ctrl.slot_rd) begin
         slot_rdata_ff <= slot_mem[slot_idx];
      end
   end

   assign tray_rdata = tray_rdata_ff;
   assign slot_valid = slot_rdata_ff[SLOT_W];
   assign slot_rdata = slot_rdata_ff[SLOT_W-1:0];

endmodule

/* hdl/tdcinl_store.sv */
// tdcinl_store: correction word store, one word per slot, channel and bin,
// in a single-port synchronous memory with registered read data.
// Depends on tdcinl_pkg.
module tdcinl_store #(
   parameter int MAX_BOARDS         = 16,
   parameter int CHANNELS_PER_BOARD = 24,
   parameter int BINS               = 1024,
   parameter int CLR_W              = 19,
   localparam int ROWS              = MAX_BOARDS * CHANNELS_PER_BOARD,
   localparam int ROW_W             = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                        clock,
   input  tdcinl_pkg::store_ctrl_type  ctrl,
   input  logic [CLR_W-1:0]            clr_idx,
   input  logic [ROW_W-1:0]            row,
   input  tdcinl_pkg::bin_type         bin,
   input  tdcinl_pkg::corr_type        wdata,
   output tdcinl_pkg::corr_type        rdata
);
   import tdcinl_pkg::*;

   localparam int ST_DEPTH = ROWS * BINS;
   localparam int ST_AW    = $clog2(ST_DEPTH);

   corr_type           corr_mem [ST_DEPTH];
   corr_type           rdata_ff;
   logic [ST_AW-1:0]   addr;
   logic               clr_hit;

   // Word address: row * bins + bin (row comes from a register)
   assign addr    = ST_AW'(row) * ST_AW'(BINS) + ST_AW'(bin);
   assign clr_hit = {1'b0, clr_idx} < (CLR_W + 1)'(ST_DEPTH);

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         if (clr_hit) begin
            corr_mem[ST_AW'(clr_idx)] <= '0;
         end
      end else if (ctrl.wr) begin
         corr_mem[addr] <= wdata;
      end
      if (ctrl.rd) begin
         rdata_ff <= corr_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for tdc_inl_correction_lookup: directed and random
// beats of map loads, correction loads and lookups, checked against a predictor.
// Depends on tdcinl_pkg and the tdc_inl_correction_lookup RTL.
module testbench;
   import tdcinl_pkg::*;

   localparam int TRAYS        = 120;
   localparam int BPT          = 8;
   localparam int CPB          = 24;
   localparam int NBINS        = 1024;
   localparam int SLOTS        = 16;
   localparam int TOP_ID       = 1023;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct {
      action_type   action;
      tray_type     tray;
      position_type position;
      board_id_type board_id;
      channel_type  channel;
      bin_type      bin;
      corr_type     value;
   } tdc_req_type;

   typedef struct {
      corr_type   correction;
      status_type status;
   } inl_result_type;

   // A correction word that was loaded, kept so lookups can hit real entries
   typedef struct {
      board_id_type id;
      channel_type  ch;
      bin_type      bin;
   } loaded_word_type;

   // Shadow of the correction table and queue of results still owed
   class correction_tracker_type;
      bit [9:0]       board_at [(TRAYS + 2) * BPT];
      bit [4:0]       slot_of [TOP_ID + 1];
      bit             slot_ok [TOP_ID + 1];
      bit [15:0]      inl_word [SLOTS * CPB * NBINS];
      int unsigned    slots_used;
      bit [9:0]       current_board;
      inl_result_type pending_results [$];
      int             errors;

      // Board ID and on-board channel to a word; missing table falls back
      function void read_board(int id, int chan, int bin, bit chan_ok,
                               output inl_result_type res);
         int slot;
         bit have;
         slot = 0;
         have = 1'b0;
         if (chan_ok && id >= 1 && id <= TOP_ID && slot_ok[id]) begin
            slot = slot_of[id];
            have = (slot < slots_used);
         end
         if (have) begin
            res.correction = corr_type'(inl_word[(slot * CPB + chan) * NBINS + bin]);
            res.status     = ST_OK;
         end else begin
            res.correction = corr_type'(inl_word[bin]);
            res.status     = ST_FALLBACK;
         end
      endfunction

      function void accept_request(tdc_req_type r);
         int             tray;
         int             pos;
         int             id;
         int             chan;
         int             bin;
         int             board;
         bit             taken;
         inl_result_type res;
         tray = r.tray;
         pos  = r.position;
         id   = r.board_id;
         chan = r.channel;
         bin  = r.bin;
         res.correction = '0;
         res.status     = ST_OK;
         case (r.action)
            ACT_LOAD_MAP: begin
               if (tray >= 1 && tray <= TRAYS + 2 && pos < BPT)
                  board_at[(tray - 1) * BPT + pos] = r.board_id;
               else
                  res.status = ST_RANGE;
            end
            ACT_LOAD_CORR: begin
               taken = 1'b1;
               // a change of board takes the next slot, until slots run out
               if (slots_used == 0 || r.board_id != current_board) begin
                  if (slots_used >= SLOTS) begin
                     taken = 1'b0;
                  end else begin
                     if (id >= 1 && id <= TOP_ID) begin
                        slot_of[id] = slots_used[4:0];
                        slot_ok[id] = 1'b1;
                     end
                     slots_used++;
                  end
               end
               if (!taken) begin
                  res.status = ST_RANGE;
               end else begin
                  current_board = r.board_id;
                  if (chan < CPB && bin < NBINS)
                     inl_word[((slots_used - 1) * CPB + chan) * NBINS + bin] = r.value;
                  else
                     res.status = ST_RANGE;
               end
            end
            ACT_BY_TRAY: begin
               if (tray < 1 || tray > TRAYS + 2 || chan >= BPT * CPB || bin >= NBINS) begin
                  res.status = ST_RANGE;
               end else begin
                  board = board_at[(tray - 1) * BPT + chan / CPB];
                  if (board < 1 || board > TOP_ID)
                     res.status = ST_RANGE;
                  else
                     read_board(board, chan % CPB, bin, 1'b1, res);
               end
            end
            ACT_BY_BOARD: begin
               if (bin >= NBINS)
                  res.status = ST_RANGE;
               else
                  read_board(id, chan, bin, chan < CPB, res);
            end
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_result(corr_type corr, status_type status);
         inl_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: correction %0d status %0d", corr, status);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (corr !== want.correction) begin
            $error("correction: expected %0d, actual %0d", want.correction, corr);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   action_type   req_action;
   tray_type     req_tray;
   position_type req_position;
   board_id_type req_board_id;
   channel_type  req_channel;
   bin_type      req_bin;
   corr_type     req_value;
   logic         rsp_valid;
   logic         rsp_stall;
   corr_type     rsp_correction;
   status_type   rsp_status;

   correction_tracker_type results;
   bit                     idle_on;
   loaded_word_type        written [$];
   board_id_type           known_ids [$];

   tdc_inl_correction_lookup uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_tray       (req_tray),
      .req_position   (req_position),
      .req_board_id   (req_board_id),
      .req_channel    (req_channel),
      .req_bin        (req_bin),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_correction (rsp_correction),
      .rsp_status     (rsp_status)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure in random bursts
   always begin
      @(posedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 13)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Result beats against the predictor
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         results.check_result(rsp_correction, rsp_status);
   end

   function automatic tdc_req_type make_req(action_type act, int tray, int pos, int id,
                                            int ch, int bin, int value);
      tdc_req_type r;
      r.action   = act;
      r.tray     = tray_type'(tray);
      r.position = position_type'(pos);
      r.board_id = board_id_type'(id);
      r.channel  = channel_type'(ch);
      r.bin      = bin_type'(bin);
      r.value    = corr_type'(value);
      return r;
   endfunction

   function automatic tdc_req_type noise_req();
      return make_req(action_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
   endfunction

   // Present one beat, hold it until accepted, then maybe leave a gap
   task automatic send_beat(tdc_req_type r);
      req_valid    <= 1'b1;
      req_action   <= r.action;
      req_tray     <= r.tray;
      req_position <= r.position;
      req_board_id <= r.board_id;
      req_channel  <= r.channel;
      req_bin      <= r.bin;
      req_value    <= r.value;
      do @(posedge clock); while (req_stall !== 1'b0);
      results.accept_request(r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (results.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic note_word(tdc_req_type r);
      loaded_word_type w;
      w.id  = r.board_id;
      w.ch  = r.channel;
      w.bin = r.bin;
      written.push_back(w);
   endtask

   // One random item; mostly loads and lookups that hit loaded words
   task automatic random_beat();
      tdc_req_type     r;
      tdc_req_type     m;
      loaded_word_type w;
      int              sel;
      int              k;
      int              tray;
      int              pos;
      sel = $urandom_range(0, 99);
      r   = noise_req();
      if (sel < 5) begin
         // pure noise
      end else if (sel < 17) begin
         r.action = ACT_LOAD_MAP;
         if ($urandom_range(0, 9) != 0)
            r.tray = tray_type'($urandom_range(1, TRAYS + 2));
         if ($urandom_range(0, 3) != 0)
            r.board_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
      end else if (sel < 42) begin
         r.action = ACT_LOAD_CORR;
         k = $urandom_range(0, 11);
         if (k == 0) begin
            known_ids.push_back(r.board_id);
         end else if (k == 1) begin
            r.board_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
         end else begin
            r.board_id = results.current_board;
         end
         if ($urandom_range(0, 9) != 0)
            r.channel = channel_type'($urandom_range(0, CPB - 1));
         if (r.channel < CPB)
            note_word(r);
      end else if (sel < 70) begin
         r.action = ACT_BY_TRAY;
         if ($urandom_range(0, 4) != 0) begin
            w    = written[$urandom_range(0, written.size() - 1)];
            tray = $urandom_range(1, TRAYS + 2);
            pos  = $urandom_range(0, BPT - 1);
            // map the board onto the tray first where it is not there yet
            if (results.board_at[(tray - 1) * BPT + pos] != w.id) begin
               m          = noise_req();
               m.action   = ACT_LOAD_MAP;
               m.tray     = tray_type'(tray);
               m.position = position_type'(pos);
               m.board_id = w.id;
               send_beat(m);
            end
            r.tray    = tray_type'(tray);
            r.channel = channel_type'(pos * CPB + w.ch);
            r.bin     = w.bin;
         end
      end else begin
         r.action = ACT_BY_BOARD;
         if ($urandom_range(0, 4) != 0) begin
            w          = written[$urandom_range(0, written.size() - 1)];
            r.board_id = w.id;
            r.channel  = w.ch;
            r.bin      = w.bin;
         end
      end
      send_beat(r);
   endtask

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      tdc_req_type r;
      int          n;
      results      = new();
      idle_on      = 1'b1;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_action   <= ACT_LOAD_MAP;
      req_tray     <= '0;
      req_position <= '0;
      req_board_id <= '0;
      req_channel  <= '0;
      req_bin      <= '0;
      req_value    <= '0;
      rsp_stall    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tables, range edges, vpd trays, fallback, slot reuse
      send_beat(make_req(ACT_BY_BOARD, 0, 0, 5, 0, 0, 0));
      send_beat(make_req(ACT_BY_TRAY, 1, 0, 0, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 0, 0, 5, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 123, 7, 5, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 127, 7, 1023, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 1, 0, 5, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 122, 7, 1023, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_MAP, 121, 3, 0, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 5, 0, 0, 32767));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 5, 23, 1023, -32768));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 5, 24, 5, 77));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 5, 255, 1023, -1));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 1023, 0, 1023, 4660));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 0, 1, 1, -1));
      send_beat(make_req(ACT_BY_TRAY, 1, 0, 0, 0, 0, 0));
      send_beat(make_req(ACT_BY_TRAY, 1, 0, 0, 23, 1023, 0));
      send_beat(make_req(ACT_BY_TRAY, 122, 0, 0, 168, 1023, 0));
      send_beat(make_req(ACT_BY_TRAY, 122, 0, 0, 191, 0, 0));
      send_beat(make_req(ACT_BY_TRAY, 1, 0, 0, 192, 0, 0));
      send_beat(make_req(ACT_BY_TRAY, 121, 0, 0, 72, 0, 0));
      send_beat(make_req(ACT_BY_TRAY, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(ACT_BY_BOARD, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(ACT_BY_BOARD, 0, 0, 1023, 24, 1023, 0));
      send_beat(make_req(ACT_BY_BOARD, 0, 0, 700, 0, 0, 0));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, 5, 2, 2, 300));
      send_beat(make_req(ACT_BY_BOARD, 0, 0, 5, 23, 1023, 0));

      known_ids = '{10'd5, 10'd1023, 10'd0};
      note_word(make_req(ACT_LOAD_CORR, 0, 0, 5, 0, 0, 0));
      note_word(make_req(ACT_LOAD_CORR, 0, 0, 5, 23, 1023, 0));
      note_word(make_req(ACT_LOAD_CORR, 0, 0, 1023, 0, 1023, 0));
      note_word(make_req(ACT_LOAD_CORR, 0, 0, 0, 1, 1, 0));
      note_word(make_req(ACT_LOAD_CORR, 0, 0, 5, 2, 2, 0));

      // Random, first half, with idle stretches switched per block
      for (n = 0; n < 500; n++) begin
         if (n % 50 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         random_beat();
      end

      // Hold off until the block has answered everything
      wait_results_drained();
      idle_on = 1'b1;

      // Fill every slot, then push past the limit
      while (results.slots_used < SLOTS) begin
         r = make_req(ACT_LOAD_CORR, 0, 0, $urandom_range(1, TOP_ID), 0, 0, 0);
         known_ids.push_back(r.board_id);
         repeat (2) begin
            r.channel = channel_type'($urandom_range(0, CPB - 1));
            r.bin     = bin_type'($urandom);
            r.value   = corr_type'($urandom);
            note_word(r);
            send_beat(r);
         end
      end
      for (n = 0; n < 2; n++)
         send_beat(make_req(ACT_LOAD_CORR, 0, 0, results.current_board ^ 10'h200, 3, 7, 257));
      send_beat(make_req(ACT_LOAD_CORR, 0, 0, results.current_board, 5, 9, -5));

      // Random, second half; the tail runs with no idling at all
      for (n = 0; n < 380; n++) begin
         if (n >= 230)
            idle_on = 1'b0;
         else if (n % 50 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         random_beat();
      end

      wait_results_drained();
      repeat (12) @(posedge clock);
      if (results.errors == 0 && results.pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
